>>> src/gsdc_pkg.sv
// Package for the gamepad stick direction conditioner.
// Holds the payload structs, direction and source codes, register indexes and shared helpers.
// No dependencies.
package gsdc_pkg;

    localparam int AXIS_BITS      = 16;
    localparam int SEED_POLLS     = 6;
    localparam int DEBOUNCE_POLLS = 3;
    localparam int CENTER_SHIFT   = 5;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int SEED_CNT_BITS  = 3;
    localparam int DB_CNT_BITS    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESS_DZ   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE_DZ = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_EN    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_EN   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MENU_MODE  = 3'd4;

    localparam logic [CFG_DATA_BITS-1:0] PRESS_DZ_RESET   = 16'd8000;
    localparam logic [CFG_DATA_BITS-1:0] RELEASE_DZ_RESET = 16'd6000;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } t_dir;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_PAD   = 2'd1,
        SRC_STICK = 2'd2
    } t_src;

    typedef struct packed {
        logic signed [AXIS_BITS-1:0] left_x;
        logic signed [AXIS_BITS-1:0] left_y;
        logic signed [AXIS_BITS-1:0] right_x;
        logic signed [AXIS_BITS-1:0] right_y;
        logic                        pad_up;
        logic                        pad_down;
        logic                        pad_left;
        logic                        pad_right;
        logic                        clear_state;
    } t_in;

    typedef struct packed {
        logic dir_up;
        logic dir_down;
        logic dir_left;
        logic dir_right;
    } t_out;

    // opposite pairs cancel, then vertical wins
    function automatic t_dir collapse(input logic up, input logic down,
                                      input logic left, input logic right);
        logic u, d, l, r;
        u = up & ~down;
        d = down & ~up;
        l = left & ~right;
        r = right & ~left;
        if (u) begin
            return DIR_UP;
        end else if (d) begin
            return DIR_DOWN;
        end else if (l) begin
            return DIR_LEFT;
        end else if (r) begin
            return DIR_RIGHT;
        end
        return DIR_NONE;
    endfunction

endpackage

>>> src/gsdc_stick.sv
// One analog stick: center seeding, center tracking and debounced Schmitt direction flags.
// Depends on gsdc_pkg. State advances only on i_step.
// o_held order: left, right, up, down.
module gsdc_stick (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_step,
    input  logic                                 i_clear,
    input  logic                                 i_enable,
    input  logic signed [gsdc_pkg::AXIS_BITS-1:0] i_x,
    input  logic signed [gsdc_pkg::AXIS_BITS-1:0] i_y,
    input  logic [gsdc_pkg::AXIS_BITS-1:0]        i_press_dz,
    input  logic [gsdc_pkg::AXIS_BITS-1:0]        i_release_dz,
    output logic [3:0]                            o_held
);
    import gsdc_pkg::*;

    localparam int A = AXIS_BITS;

    logic signed [A-1:0]         r_center [2];
    logic                        r_seeded;
    logic [SEED_CNT_BITS-1:0]    r_seed_cnt;
    logic [3:0]                  r_held;
    logic [DB_CNT_BITS-1:0]      r_pc [4];
    logic [DB_CNT_BITS-1:0]      r_rc [4];

    logic signed [A-1:0]         n_center [2];
    logic                        n_seeded;
    logic [SEED_CNT_BITS-1:0]    n_seed_cnt;
    logic [3:0]                  n_held;
    logic [DB_CNT_BITS-1:0]      n_pc [4];
    logic [DB_CNT_BITS-1:0]      n_rc [4];

    logic signed [A:0]           c_axis [2];
    logic                        near_rest;

    function automatic logic [A:0] mag(input logic signed [A:0] v);
        return v[A] ? unsigned'(-v) : unsigned'(v);
    endfunction

    function automatic logic signed [A-1:0] nudge(input logic signed [A-1:0] center,
                                                  input logic signed [A-1:0] raw,
                                                  input logic [A-1:0] rdz);
        logic signed [A:0] err;
        logic signed [A:0] step;
        logic signed [A:0] sum;
        logic [A:0]        m;
        err  = {raw[A-1], raw} - {center[A-1], center};
        m    = mag(err);
        step = signed'(m >> CENTER_SHIFT);
        if (err[A]) begin
            step = -step;
        end
        sum = {center[A-1], center} + step;
        if (m > {1'b0, rdz}) begin
            return center;
        end
        return sum[A-1:0];
    endfunction

    always_comb begin
        logic                     was_seeded;
        logic [SEED_CNT_BITS-1:0] cnt;
        logic signed [A:0]        v;
        logic signed [A+1:0]      v2;
        logic signed [A+1:0]      pd2;
        logic                     want_press;
        logic                     want_release;
        logic [DB_CNT_BITS-1:0]   pc;
        logic [DB_CNT_BITS-1:0]   rc;
        logic                     held;

        n_center[0] = i_clear ? '0 : r_center[0];
        n_center[1] = i_clear ? '0 : r_center[1];
        was_seeded  = i_clear ? 1'b0 : r_seeded;
        cnt         = i_clear ? '0 : r_seed_cnt;
        n_seeded    = was_seeded;
        n_seed_cnt  = cnt;

        near_rest = (mag({i_x[A-1], i_x}) < {1'b0, i_release_dz}) &&
                    (mag({i_y[A-1], i_y}) < {1'b0, i_release_dz});
        if (!was_seeded) begin
            if (near_rest) begin
                n_seed_cnt = (cnt == '1) ? cnt : cnt + 1'b1;
                if (n_seed_cnt >= SEED_CNT_BITS'(SEED_POLLS)) begin
                    n_center[0] = i_x;
                    n_center[1] = i_y;
                    n_seeded    = 1'b1;
                end
            end else begin
                n_seed_cnt = '0;
            end
        end

        if (n_seeded) begin
            n_center[0] = nudge(n_center[0], i_x, i_release_dz);
            n_center[1] = nudge(n_center[1], i_y, i_release_dz);
            c_axis[0]   = {i_x[A-1], i_x} - {n_center[0][A-1], n_center[0]};
            c_axis[1]   = {i_y[A-1], i_y} - {n_center[1][A-1], n_center[1]};
        end else begin
            c_axis[0] = '0;
            c_axis[1] = '0;
        end

        pd2 = signed'({2'b00, i_press_dz});
        for (int k = 0; k < 4; k++) begin
            v    = c_axis[k / 2];
            v2   = {v[A], v};
            held = i_clear ? 1'b0 : r_held[k];
            pc   = i_clear ? '0 : r_pc[k];
            rc   = i_clear ? '0 : r_rc[k];
            want_press   = (k % 2 == 0) ? (v2 <= -pd2) : (v2 >= pd2);
            want_release = mag(v) < {1'b0, i_release_dz};
            if (!held) begin
                if (want_press) begin
                    pc = (pc == '1) ? pc : pc + 1'b1;
                    if (pc >= DB_CNT_BITS'(DEBOUNCE_POLLS)) begin
                        held = 1'b1;
                        rc   = '0;
                    end
                end else begin
                    pc = '0;
                end
            end else begin
                if (want_release) begin
                    rc = (rc == '1) ? rc : rc + 1'b1;
                    if (rc >= DB_CNT_BITS'(DEBOUNCE_POLLS)) begin
                        held = 1'b0;
                        pc   = '0;
                    end
                end else begin
                    rc = '0;
                end
            end
            if (!i_enable) begin
                held = 1'b0;
                pc   = '0;
                rc   = '0;
            end
            n_held[k] = held;
            n_pc[k]   = pc;
            n_rc[k]   = rc;
        end
    end

    assign o_held = n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_seeded    <= 1'b0;
            r_seed_cnt  <= '0;
            r_held      <= '0;
            for (int k = 0; k < 4; k++) begin
                r_pc[k] <= '0;
                r_rc[k] <= '0;
            end
        end else if (i_step) begin
            r_center[0] <= n_center[0];
            r_center[1] <= n_center[1];
            r_seeded    <= n_seeded;
            r_seed_cnt  <= n_seed_cnt;
            r_held      <= n_held;
            for (int k = 0; k < 4; k++) begin
                r_pc[k] <= n_pc[k];
                r_rc[k] <= n_rc[k];
            end
        end
    end

endmodule

>>> src/gamepad_stick_direction_conditioner.sv
// Top level of the gamepad stick direction conditioner.
// Depends on gsdc_pkg and gsdc_stick (one instance per stick).
//
// Usage:
//   Input channel (i_valid / o_stall / i_data) carries one poll per item: four
//   raw axes, four d-pad bits and a clear bit. Output channel (o_valid / i_stall
//   / o_data) returns one item with up, down, left and right for every poll.
//   Config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes the deadzones, the
//   stick enables and the menu mode; unknown indexes are ignored. Write it only
//   while no poll is in flight.
//   An accepted poll waits in the input register; its result goes to the result register.
//   Throughput: one poll per cycle while the receiver does not stall; the whole
//   poll is evaluated in the single logic stage between the input register and
//   the result register. When the receiver stalls, the result register holds,
//   one more poll waits in the input register, and o_stall then rises until the
//   result is taken. Reset clears centers, seeding, debounce state, arbitration
//   history, empties both pipeline registers and loads the default configuration.
module gamepad_stick_direction_conditioner (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  gsdc_pkg::t_in                        i_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output gsdc_pkg::t_out                       o_data,
    input  logic                                 i_cfg_we,
    input  logic [gsdc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [gsdc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import gsdc_pkg::*;

    logic                    r_in_valid;
    t_in                     r_in;
    logic                    r_out_valid;
    t_out                    r_out;
    t_out                    n_out;

    logic [AXIS_BITS-1:0]    r_press_dz;
    logic [AXIS_BITS-1:0]    r_release_dz;
    logic                    r_left_en;
    logic                    r_right_en;
    logic                    r_menu;

    t_dir                    r_last_pad;
    t_dir                    r_last_stick;
    t_src                    r_last_src;
    t_src                    n_last_src;
    t_dir                    pad_dir;
    t_dir                    stk_dir;

    logic                    advance;
    logic [3:0]              held_l;
    logic [3:0]              held_r;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    gsdc_stick u_left (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_clear      (r_in.clear_state),
        .i_enable     (r_left_en),
        .i_x          (r_in.left_x),
        .i_y          (r_in.left_y),
        .i_press_dz   (r_press_dz),
        .i_release_dz (r_release_dz),
        .o_held       (held_l)
    );

    gsdc_stick u_right (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_clear      (r_in.clear_state),
        .i_enable     (r_right_en),
        .i_x          (r_in.right_x),
        .i_y          (r_in.right_y),
        .i_press_dz   (r_press_dz),
        .i_release_dz (r_release_dz),
        .o_held       (held_r)
    );

    always_comb begin
        logic s_up, s_down, s_left, s_right;
        logic up, down, left, right;
        t_dir chosen;

        s_up    = held_l[2] | held_r[2];
        s_down  = held_l[3] | held_r[3];
        s_left  = held_l[0] | held_r[0];
        s_right = held_l[1] | held_r[1];
        if (s_up && s_down) begin
            s_up   = 1'b0;
            s_down = 1'b0;
        end
        if (s_left && s_right) begin
            s_left  = 1'b0;
            s_right = 1'b0;
        end

        pad_dir = collapse(r_in.pad_up, r_in.pad_down, r_in.pad_left, r_in.pad_right);
        stk_dir = r_menu ? collapse(s_up, s_down, s_left, s_right) : DIR_NONE;

        n_last_src = r_last_src;
        if (pad_dir != r_last_pad && pad_dir != DIR_NONE) begin
            n_last_src = SRC_PAD;
        end
        if (stk_dir != r_last_stick && stk_dir != DIR_NONE) begin
            n_last_src = SRC_STICK;
        end

        if (stk_dir != DIR_NONE && pad_dir != DIR_NONE) begin
            chosen = (n_last_src == SRC_STICK) ? stk_dir : pad_dir;
        end else if (stk_dir != DIR_NONE) begin
            chosen = stk_dir;
        end else begin
            chosen = pad_dir;
        end

        if (r_menu) begin
            up    = (chosen == DIR_UP);
            down  = (chosen == DIR_DOWN);
            left  = (chosen == DIR_LEFT);
            right = (chosen == DIR_RIGHT);
        end else begin
            up    = r_in.pad_up    | s_up;
            down  = r_in.pad_down  | s_down;
            left  = r_in.pad_left  | s_left;
            right = r_in.pad_right | s_right;
            if (up && down) begin
                up   = 1'b0;
                down = 1'b0;
            end
            if (left && right) begin
                left  = 1'b0;
                right = 1'b0;
            end
        end

        n_out.dir_up    = up;
        n_out.dir_down  = down;
        n_out.dir_left  = left;
        n_out.dir_right = right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_pad   <= DIR_NONE;
            r_last_stick <= DIR_NONE;
            r_last_src   <= SRC_NONE;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_last_pad   <= pad_dir;
                r_last_stick <= stk_dir;
                r_last_src   <= n_last_src;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_dz   <= PRESS_DZ_RESET;
            r_release_dz <= RELEASE_DZ_RESET;
            r_left_en    <= 1'b1;
            r_right_en   <= 1'b1;
            r_menu       <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRESS_DZ: begin
                    r_press_dz <= i_cfg_data[AXIS_BITS-1:0];
                end
                CFG_RELEASE_DZ: begin
                    r_release_dz <= i_cfg_data[AXIS_BITS-1:0];
                end
                CFG_LEFT_EN: begin
                    r_left_en <= i_cfg_data[0];
                end
                CFG_RIGHT_EN: begin
                    r_right_en <= i_cfg_data[0];
                end
                CFG_MENU_MODE: begin
                    r_menu <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule
